/* rtl/core/dlfb_pkg.sv */
// ----------------------------------------------------------------------------
// Dense layer package
// Shared types, constants and helper functions for the dense layer block.
// ----------------------------------------------------------------------------
`default_nettype none
package dlfb_pkg;

  localparam int unsigned InFeatures  = 4;
  localparam int unsigned OutFeatures = 4;
  localparam int unsigned Batch       = 4;
  localparam int unsigned NumCells    = 4;
  localparam int unsigned AccW        = 40;
  localparam logic signed [15:0] WeightInit = 16'sd26;
  localparam logic [2:0] BatchRowsReset = 3'd4;

  typedef enum logic [1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_ACT    = 2'd1,
    REQ_GRAD   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_FWD   = 2'd0,
    KIND_WGRAD = 2'd1,
    KIND_BGRAD = 2'd2,
    KIND_IGRAD = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_OUT  = 2'd2
  } state_e;

  // One cell operation: operands enter the chain at cell 0. The index tells
  // which cell of the chain takes the term.
  typedef struct packed {
    logic               valid;
    logic               clear;
    logic               use_b;
    logic [1:0]         idx;
    logic signed [15:0] a;
    logic signed [15:0] b;
  } cell_op_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [15:0] value;
    logic               last;
  } req_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [15:0] result_value;
    logic               end_of_run;
  } rsp_t;

  // Saturate a wide sum to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] v);
    logic signed [15:0] r;
    if (v > $signed(AccW'(32767))) r = 16'sh7fff;
    else if (v < -$signed(AccW'(32768))) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Round half up from Q16.16 to Q8.8, then saturate.
  function automatic logic signed [15:0] to_q88(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] x;
    x = (acc + $signed(AccW'(128))) >>> 8;
    return sat16(x);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/dlfb_if.sv */
// ----------------------------------------------------------------------------
// Dense layer stream interface
// Valid/ready channel carrying one request or result payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface dlfb_req_if;
  import dlfb_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dlfb_rsp_if;
  import dlfb_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/dlfb_cell.sv */
// ----------------------------------------------------------------------------
// Dense layer MAC cell
// One cell of the chain: multiplies (or passes) the operands, accumulates,
// and forwards the operation to its neighbor through a register.
// ----------------------------------------------------------------------------
`default_nettype none
module dlfb_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  dlfb_pkg::cell_op_t      op_i,
  output dlfb_pkg::cell_op_t      op_o,
  output logic signed [dlfb_pkg::AccW-1:0] acc_o
);
  import dlfb_pkg::*;

  cell_op_t op_q;
  logic signed [AccW-1:0] acc_q, acc_d, term;
  logic signed [31:0] prod;

  // Product or plain operand (bias sums add the value alone).
  always_comb begin
    prod = op_i.a * op_i.b;
    if (op_i.use_b) term = AccW'(prod);
    else term = AccW'(op_i.a) <<< 8;
    acc_d = acc_q;
    if (op_i.valid && take_i) acc_d = (op_i.clear ? '0 : acc_q) + term;
  end

  // Every operation moves on to the neighbor, taken here or not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else begin
      op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign op_o  = op_q;
  assign acc_o = acc_q;
endmodule
`default_nettype wire

/* rtl/core/dense_layer_forward_backward.sv */
// ----------------------------------------------------------------------------
// Dense layer forward/backward
// Fully connected layer with Q8.8 loads and saturated Q8.8 results.
// ----------------------------------------------------------------------------
// Usage: weights, activations and output gradients enter on req one
// transaction each. An activation with last produces batch_rows*4 forward
// results; a gradient with last produces 16 weight-gradient, 4 bias and
// batch_rows*4 input-gradient results, with batch_rows taken as 1 when 0
// and as 4 above 4. Each result is a dot product of up to four terms
// (batch_rows terms for weight-gradient and bias results) computed by a
// chain of four MAC cells: one term enters per cycle and term k is taken
// by cell k. The sequencer feeds the terms of one result, waits for the
// chain, then loads the result register; the next result starts only
// after that load. While a run is busy req is not ready. Reset sets all
// weights to 26 (0.1) and batch_rows to 4; activation and gradient stores
// are undefined until written. A stalled receiver holds the result
// register and the sequencer waits on it.
// ----------------------------------------------------------------------------
`default_nettype none
module dense_layer_forward_backward (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  dlfb_req_if.sink        req,
  dlfb_rsp_if.source      rsp,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_wdata_i
);
  import dlfb_pkg::*;

  logic signed [15:0] w_q [16];
  logic signed [15:0] x_q [16];
  logic signed [15:0] g_q [16];
  logic [2:0] rows_q;
  logic [1:0] used_max;

  state_e state_q, state_d;
  logic [1:0] phase_q, phase_d;   // kind being produced
  logic [1:0] r_q, r_d, c_q, c_d; // element position
  logic [2:0] k_q, k_d;           // term index fed to the chain
  logic [2:0] wait_q, wait_d;

  cell_op_t chain [NumCells+1];
  logic signed [AccW-1:0] acc [NumCells];
  logic [NumCells-1:0] mask_q;
  logic signed [AccW-1:0] sum;

  rsp_t out_q;
  logic out_v_q;
  logic fire_out;
  logic last_elem;
  logic [1:0] n_terms;

  // Configuration and stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= BatchRowsReset;
      for (int i = 0; i < 16; i++) w_q[i] <= WeightInit;
    end else begin
      if (cfg_we_i) rows_q <= cfg_wdata_i;
      if (req.valid && req.ready && req.payload.req_type == REQ_WEIGHT)
        w_q[{req.payload.row, req.payload.col}] <= req.payload.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready && req.payload.req_type == REQ_ACT)
      x_q[{req.payload.row, req.payload.col}] <= req.payload.value;
    if (req.valid && req.ready && req.payload.req_type == REQ_GRAD)
      g_q[{req.payload.row, req.payload.col}] <= req.payload.value;
  end

  always_comb begin
    if (rows_q == 3'd0) used_max = 2'd0;
    else if (rows_q > 3'd4) used_max = 2'd3;
    else used_max = 2'(rows_q - 3'd1);
  end

  assign req.ready = (state_q == ST_IDLE);

  // Operand for term k of the current element. Each cell keeps a single
  // term, so every operation clears its accumulator.
  always_comb begin
    chain[0] = '0;
    chain[0].valid = (state_q == ST_RUN) && (k_q <= {1'b0, n_terms});
    chain[0].clear = 1'b1;
    chain[0].use_b = 1'b1;
    chain[0].idx = k_q[1:0];
    case (phase_q)
      KIND_FWD: begin
        chain[0].a = x_q[{r_q, k_q[1:0]}];
        chain[0].b = w_q[{k_q[1:0], c_q}];
      end
      KIND_WGRAD: begin
        chain[0].a = x_q[{k_q[1:0], r_q}];
        chain[0].b = g_q[{k_q[1:0], c_q}];
      end
      KIND_BGRAD: begin
        chain[0].a = g_q[{k_q[1:0], c_q}];
        chain[0].b = '0;
        chain[0].use_b = 1'b0;
      end
      default: begin
        chain[0].a = g_q[{r_q, k_q[1:0]}];
        chain[0].b = w_q[{c_q, k_q[1:0]}];
      end
    endcase
  end

  // Term k travels down the chain and only cell k takes it.
  for (genvar gi = 0; gi < NumCells; gi++) begin : g_cells
    logic take;
    assign take = (chain[gi].idx == 2'(gi));
    dlfb_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .take_i(take),
      .op_i  (chain[gi]),
      .op_o  (chain[gi+1]),
      .acc_o (acc[gi])
    );
  end

  always_comb begin
    n_terms = (phase_q == KIND_IGRAD) ? 2'd3 : (phase_q == KIND_FWD ? 2'd3 : used_max);
    sum = '0;
    for (int i = 0; i < NumCells; i++)
      if (mask_q[i]) sum = sum + acc[i];
  end

  assign fire_out = out_v_q && rsp.ready;

  always_comb begin
    last_elem = 1'b0;
    case (phase_q)
      KIND_FWD:   last_elem = (r_q == used_max) && (c_q == 2'd3);
      KIND_WGRAD: last_elem = 1'b0;
      KIND_BGRAD: last_elem = 1'b0;
      default:    last_elem = (r_q == used_max) && (c_q == 2'd3);
    endcase
  end

  // Sequencer: feed terms, wait for the chain, then emit.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    r_d = r_q;
    c_d = c_q;
    k_d = k_q;
    wait_d = wait_q;
    case (state_q)
      ST_IDLE: begin
        if (req.valid && req.payload.last &&
            (req.payload.req_type == REQ_ACT || req.payload.req_type == REQ_GRAD)) begin
          state_d = ST_RUN;
          phase_d = (req.payload.req_type == REQ_ACT) ? KIND_FWD : KIND_WGRAD;
          r_d = '0;
          c_d = '0;
          k_d = '0;
        end
      end
      ST_RUN: begin
        if (k_q == {1'b0, n_terms}) begin
          state_d = ST_OUT;
          wait_d = 3'd0;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      ST_OUT: begin
        if (wait_q != 3'd3) wait_d = wait_q + 3'd1;
        else if (!out_v_q || fire_out) begin
          k_d = '0;
          state_d = ST_RUN;
          c_d = c_q + 2'd1;
          case (phase_q)
            KIND_FWD: begin
              if (c_q == 2'd3) r_d = r_q + 2'd1;
              if (last_elem) state_d = ST_IDLE;
            end
            KIND_WGRAD: begin
              if (c_q == 2'd3) begin
                r_d = r_q + 2'd1;
                if (r_q == 2'd3) begin
                  phase_d = KIND_BGRAD;
                  r_d = '0;
                end
              end
            end
            KIND_BGRAD: begin
              if (c_q == 2'd3) phase_d = KIND_IGRAD;
            end
            default: begin
              if (c_q == 2'd3) r_d = r_q + 2'd1;
              if (last_elem) state_d = ST_IDLE;
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= KIND_FWD;
      r_q <= '0;
      c_q <= '0;
      k_q <= '0;
      wait_q <= '0;
      out_v_q <= 1'b0;
      mask_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      r_q <= r_d;
      c_q <= c_d;
      k_q <= k_d;
      wait_q <= wait_d;
      if (state_q == ST_RUN && k_q == 3'd0) mask_q <= '0;
      if (chain[0].valid) mask_q[k_q[1:0]] <= 1'b1;
      if (state_q == ST_OUT && wait_q == 3'd3 && (!out_v_q || fire_out)) out_v_q <= 1'b1;
      else if (fire_out) out_v_q <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && wait_q == 3'd3 && (!out_v_q || fire_out)) begin
      out_q.kind <= phase_q;
      out_q.out_row <= r_q;
      out_q.out_col <= c_q;
      out_q.result_value <= (phase_q == KIND_BGRAD) ? sat16(sum >>> 8) : to_q88(sum);
      out_q.end_of_run <= last_elem;
    end
  end

  assign rsp.valid = out_v_q;
  assign rsp.payload = out_q;

  // Input is never taken while a run is in flight.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !req.ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !rsp.ready) |=> out_v_q) else $error("result dropped");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (k_q <= 3'd3)) else $error("term index overrun");
endmodule
`default_nettype wire
